>>> hdl/plob_pkg.sv
// Package for the price level order book: sizes, codes and the structs that
// pass between the cells, the side chains and the top level. No dependencies.
package plob_pkg;

    localparam int BOOK_DEPTH = 64;
    localparam int MAX_READ   = 31;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int ID_W       = 63;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 40;
    localparam int RC_W       = 5;

    localparam logic [1:0] ACT_SNAP  = 2'd0;
    localparam logic [1:0] ACT_DIFF  = 2'd1;
    localparam logic [1:0] ACT_LEVEL = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BID    = 2'd1;
    localparam logic [1:0] KIND_ASK    = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STALE   = 3'd1;
    localparam logic [2:0] ST_GAP     = 3'd2;
    localparam logic [2:0] ST_NOSYNC  = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE, MODE_SNAP, MODE_DIFF, MODE_DISCARD
    } t_mode;

    typedef enum logic [2:0] {
        SOP_HOLD, SOP_CLEAR, SOP_INSERT, SOP_DELETE, SOP_SET, SOP_ROTATE
    } t_side_op;

    typedef enum logic [1:0] {
        S_IDLE, S_EXEC, S_RDB, S_RDA
    } t_state;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_entry;

    typedef struct packed {
        t_side_op           op;
        logic               ask;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_side_ctl;

    typedef struct packed {
        logic             found;
        logic             any_after;
        logic [CNT_W-1:0] count;
        t_entry           head;
    } t_side_stat;

endpackage

>>> hdl/plob_if.sv
// Handshake channels of the order book: input items and result items.
// Depends on plob_pkg.
interface plob_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [plob_pkg::ID_W-1:0]     update_id;
    logic [plob_pkg::ID_W-1:0]     first_update_id;
    logic [plob_pkg::ID_W-1:0]     prev_final_id;
    logic                          side;
    logic [plob_pkg::PRICE_W-1:0]  price;
    logic [plob_pkg::QTY_W-1:0]    quantity;
    logic [plob_pkg::RC_W-1:0]     read_count;
    modport source (output valid, action, update_id, first_update_id, prev_final_id,
                    side, price, quantity, read_count, input ready);
    modport sink (input valid, action, update_id, first_update_id, prev_final_id,
                  side, price, quantity, read_count, output ready);
endinterface

interface plob_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [2:0]                    status;
    logic [plob_pkg::PRICE_W-1:0]  level_price;
    logic [plob_pkg::QTY_W-1:0]    level_quantity;
    logic                          last;
    modport source (output valid, kind, status, level_price, level_quantity, last,
                    input ready);
    modport sink (input valid, kind, status, level_price, level_quantity, last,
                  output ready);
endinterface

>>> hdl/plob_cell.sv
// One cell of a sorted price level chain: holds one level and takes its
// neighbor's level on insert, delete and rotate. Depends on plob_pkg.
module plob_cell (
    input  logic                i_clk,
    input  plob_pkg::t_side_ctl i_cmd,
    input  plob_pkg::t_entry    i_left,
    input  plob_pkg::t_entry    i_right,
    input  plob_pkg::t_entry    i_head,
    input  logic                i_valid,
    input  logic                i_left_before,
    input  logic                i_wrap,
    output plob_pkg::t_entry    o_entry,
    output logic                o_before,
    output logic                o_match
);
    plob_pkg::t_entry r_entry;
    plob_pkg::t_entry n_entry;
    plob_pkg::t_entry w_new;
    logic             w_new_better;

    assign w_new.price  = i_cmd.price;
    assign w_new.qty    = i_cmd.qty;
    assign w_new_better = i_cmd.ask ? (i_cmd.price < r_entry.price)
                                    : (i_cmd.price > r_entry.price);
    assign o_match  = i_valid && (r_entry.price == i_cmd.price);
    assign o_before = i_valid && !w_new_better && (r_entry.price != i_cmd.price);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            plob_pkg::SOP_INSERT: begin
                if (!o_before) begin
                    n_entry = i_left_before ? w_new : i_left;
                end
            end
            plob_pkg::SOP_DELETE: begin
                if (!o_before) begin
                    n_entry = i_right;
                end
            end
            plob_pkg::SOP_SET: begin
                if (o_match) begin
                    n_entry.qty = i_cmd.qty;
                end
            end
            plob_pkg::SOP_ROTATE: begin
                n_entry = i_wrap ? i_head : i_right;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

>>> hdl/plob_side.sv
// One side of the book: a chain of plob_cell plus the level count.
// Depends on plob_pkg and plob_cell.
module plob_side (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  plob_pkg::t_side_ctl  i_ctl,
    output plob_pkg::t_side_stat o_stat
);
    localparam int D = plob_pkg::BOOK_DEPTH;

    logic [plob_pkg::CNT_W-1:0] r_count;
    logic [plob_pkg::CNT_W-1:0] n_count;
    plob_pkg::t_entry           w_entry [D];
    logic [D-1:0]               w_before;
    logic [D-1:0]               w_match;
    logic [D-1:0]               w_valid;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            plob_pkg::t_entry w_left;
            plob_pkg::t_entry w_right;
            logic             w_lb;
            logic             w_wrap;
            if (g == 0) begin : g_first
                assign w_left = w_entry[0];
                assign w_lb   = 1'b1;
            end else begin : g_mid
                assign w_left = w_entry[g-1];
                assign w_lb   = w_before[g-1];
            end
            if (g == D - 1) begin : g_end
                assign w_right = w_entry[0];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end
            assign w_valid[g] = (plob_pkg::CNT_W'(g) < r_count);
            assign w_wrap     = (plob_pkg::CNT_W'(g + 1) == r_count);
            plob_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (i_ctl),
                .i_left        (w_left),
                .i_right       (w_right),
                .i_head        (w_entry[0]),
                .i_valid       (w_valid[g]),
                .i_left_before (w_lb),
                .i_wrap        (w_wrap),
                .o_entry       (w_entry[g]),
                .o_before      (w_before[g]),
                .o_match       (w_match[g])
            );
        end
    endgenerate

    assign o_stat.found     = |w_match;
    assign o_stat.any_after = |(w_valid & ~w_before);
    assign o_stat.count     = r_count;
    assign o_stat.head      = w_entry[0];

    always_comb begin
        n_count = r_count;
        case (i_ctl.op)
            plob_pkg::SOP_CLEAR:  n_count = '0;
            plob_pkg::SOP_INSERT: begin
                if (r_count != plob_pkg::CNT_W'(D)) begin
                    n_count = r_count + 1'b1;
                end
            end
            plob_pkg::SOP_DELETE: n_count = r_count - 1'b1;
            default:              n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule

>>> hdl/price_level_order_book_core.sv
// Top level of the price level order book: sequencer, header checks, output
// register and the bid and ask chains. Depends on plob_pkg, plob_if, plob_side.
//
//  channel | dir | modport | carries
//  i_in    | in  | sink    | action, ids, side, price, quantity, read_count
//  o_out   | out | source  | kind, status, level_price, level_quantity, last
//
// Headers and levels are latched, then applied in one chain step in every cell.
// In a read each chain rotates once around, one level per cycle while the output
// is not stalled, with the head cell feeding the output register.
// Reset (i_rst_n low, synchronous) clears counts, id, sync flag and mode.
// A stalled output holds the sequencer; input is taken only when idle.
module price_level_order_book_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plob_in_if.sink   i_in,
    plob_out_if.source o_out
);
    localparam int CW = plob_pkg::CNT_W;

    plob_pkg::t_state   r_state, n_state;
    plob_pkg::t_mode    r_mode, n_mode;
    logic               r_sync, n_sync;
    logic [plob_pkg::ID_W-1:0] r_last_id, n_last_id;
    logic [CW-1:0]      r_step, n_step;

    logic [1:0]                    r_act;
    logic [plob_pkg::ID_W-1:0]     r_uid, r_fid, r_pid;
    logic                          r_side;
    logic [plob_pkg::PRICE_W-1:0]  r_price;
    logic [plob_pkg::QTY_W-1:0]    r_qty;
    logic [plob_pkg::RC_W-1:0]     r_rc;

    logic                          r_ov, n_ov;
    logic [1:0]                    r_kind, n_kind;
    logic [2:0]                    r_status, n_status;
    logic [plob_pkg::PRICE_W-1:0]  r_oprice, n_oprice;
    logic [plob_pkg::QTY_W-1:0]    r_oqty, n_oqty;
    logic                          r_olast, n_olast;

    plob_pkg::t_side_ctl  w_bid_ctl, w_ask_ctl;
    plob_pkg::t_side_stat w_bid, w_ask, w_sel;
    plob_pkg::t_side_op   w_op;
    logic                 w_slot;
    logic                 w_accept;
    logic [CW-1:0]        w_n;
    logic [plob_pkg::ID_W:0] w_next;

    assign i_in.ready = (r_state == plob_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_slot     = !r_ov || o_out.ready;
    assign w_sel      = r_side ? w_ask : w_bid;
    assign w_n        = (r_rc > plob_pkg::RC_W'(plob_pkg::MAX_READ))
                        ? CW'(plob_pkg::MAX_READ) : CW'(r_rc);
    assign w_next     = {1'b0, r_last_id} + 1'b1;

    assign o_out.valid          = r_ov;
    assign o_out.kind           = r_kind;
    assign o_out.status         = r_status;
    assign o_out.level_price    = r_oprice;
    assign o_out.level_quantity = r_oqty;
    assign o_out.last           = r_olast;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_sync    = r_sync;
        n_last_id = r_last_id;
        n_step    = r_step;
        n_ov      = r_ov && !o_out.ready;
        n_kind    = r_kind;
        n_status  = r_status;
        n_oprice  = r_oprice;
        n_oqty    = r_oqty;
        n_olast   = r_olast;
        w_op      = plob_pkg::SOP_HOLD;
        w_bid_ctl = '{op: plob_pkg::SOP_HOLD, ask: 1'b0, price: r_price, qty: r_qty};
        w_ask_ctl = '{op: plob_pkg::SOP_HOLD, ask: 1'b1, price: r_price, qty: r_qty};
        unique case (r_state)
            plob_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = plob_pkg::S_EXEC;
                end
            end
            plob_pkg::S_EXEC: begin
                if (w_slot) begin
                    n_ov     = 1'b1;
                    n_kind   = plob_pkg::KIND_STATUS;
                    n_status = plob_pkg::ST_OK;
                    n_oprice = '0;
                    n_oqty   = '0;
                    n_olast  = 1'b1;
                    n_state  = plob_pkg::S_IDLE;
                    unique case (r_act)
                        plob_pkg::ACT_SNAP: begin
                            w_bid_ctl.op = plob_pkg::SOP_CLEAR;
                            w_ask_ctl.op = plob_pkg::SOP_CLEAR;
                            n_last_id    = r_uid;
                            n_sync       = 1'b1;
                            n_mode       = plob_pkg::MODE_SNAP;
                        end
                        plob_pkg::ACT_DIFF: begin
                            n_mode = plob_pkg::MODE_DISCARD;
                            if (!r_sync) begin
                                n_status = plob_pkg::ST_NOSYNC;
                            end else if (r_uid < r_last_id) begin
                                n_status = plob_pkg::ST_STALE;
                            end else if (!(({1'b0, r_fid} <= w_next && w_next <= {1'b0, r_uid})
                                           || r_pid == r_last_id)) begin
                                n_sync   = 1'b0;
                                n_status = plob_pkg::ST_GAP;
                            end else begin
                                n_last_id = r_uid;
                                n_mode    = plob_pkg::MODE_DIFF;
                            end
                        end
                        plob_pkg::ACT_LEVEL: begin
                            if (r_mode == plob_pkg::MODE_SNAP && r_qty == '0) begin
                                n_status = plob_pkg::ST_IGNORED;
                            end else if (r_mode == plob_pkg::MODE_SNAP
                                         || r_mode == plob_pkg::MODE_DIFF) begin
                                if (w_sel.found) begin
                                    w_op = (r_qty == '0) ? plob_pkg::SOP_DELETE
                                                         : plob_pkg::SOP_SET;
                                end else if (r_qty != '0) begin
                                    if (w_sel.count == CW'(plob_pkg::BOOK_DEPTH)) begin
                                        n_status = plob_pkg::ST_FULL;
                                        if (w_sel.any_after) begin
                                            w_op = plob_pkg::SOP_INSERT;
                                        end
                                    end else begin
                                        w_op = plob_pkg::SOP_INSERT;
                                    end
                                end
                            end else begin
                                n_status = plob_pkg::ST_IGNORED;
                            end
                            if (r_side) begin
                                w_ask_ctl.op = w_op;
                            end else begin
                                w_bid_ctl.op = w_op;
                            end
                        end
                        plob_pkg::ACT_READ: begin
                            n_ov    = r_ov && !o_out.ready;
                            n_step  = '0;
                            n_state = plob_pkg::S_RDB;
                        end
                        default: n_state = plob_pkg::S_IDLE;
                    endcase
                end
            end
            plob_pkg::S_RDB: begin
                if (w_slot) begin
                    if (r_step < w_bid.count) begin
                        w_bid_ctl.op = plob_pkg::SOP_ROTATE;
                        n_step       = r_step + 1'b1;
                        if (r_step < w_n) begin
                            n_ov     = 1'b1;
                            n_kind   = plob_pkg::KIND_BID;
                            n_status = plob_pkg::ST_OK;
                            n_oprice = w_bid.head.price;
                            n_oqty   = w_bid.head.qty;
                            n_olast  = 1'b0;
                        end
                    end else begin
                        n_step  = '0;
                        n_state = plob_pkg::S_RDA;
                    end
                end
            end
            plob_pkg::S_RDA: begin
                if (w_slot) begin
                    n_ov     = 1'b1;
                    n_status = plob_pkg::ST_OK;
                    if (r_step < w_ask.count) begin
                        w_ask_ctl.op = plob_pkg::SOP_ROTATE;
                        n_step       = r_step + 1'b1;
                        n_ov         = r_ov && !o_out.ready;
                        if (r_step < w_n) begin
                            n_ov     = 1'b1;
                            n_kind   = plob_pkg::KIND_ASK;
                            n_oprice = w_ask.head.price;
                            n_oqty   = w_ask.head.qty;
                            n_olast  = 1'b0;
                        end
                    end else begin
                        n_kind   = plob_pkg::KIND_STATUS;
                        n_oprice = '0;
                        n_oqty   = '0;
                        n_olast  = 1'b1;
                        n_state  = plob_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = plob_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= plob_pkg::S_IDLE;
            r_mode    <= plob_pkg::MODE_IDLE;
            r_sync    <= 1'b0;
            r_last_id <= '0;
            r_step    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_sync    <= n_sync;
            r_last_id <= n_last_id;
            r_step    <= n_step;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_oprice <= n_oprice;
        r_oqty   <= n_oqty;
        r_olast  <= n_olast;
        if (w_accept) begin
            r_act   <= i_in.action;
            r_uid   <= i_in.update_id;
            r_fid   <= i_in.first_update_id;
            r_pid   <= i_in.prev_final_id;
            r_side  <= i_in.side;
            r_price <= i_in.price;
            r_qty   <= i_in.quantity;
            r_rc    <= i_in.read_count;
        end
    end

    plob_side u_bid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_bid_ctl),
        .o_stat  (w_bid)
    );

    plob_side u_ask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ask_ctl),
        .o_stat  (w_ask)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bid.count <= CW'(plob_pkg::BOOK_DEPTH) && w_ask.count <= CW'(plob_pkg::BOOK_DEPTH))
        else $error("level count beyond table depth");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last |-> o_out.kind == plob_pkg::KIND_STATUS)
        else $error("final item is not a status item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("item taken while previous item still in work");
endmodule
